FILE: rtl/spq_pkg.sv
// spq_pkg: shared types and constants for the sorted priority queue
// depends on nothing; used by spq_cell and sorted_priority_queue_core
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [31:0] item_in;
        logic [31:0] priority_in;
    } spq_in_t;

    typedef struct packed {
        logic [31:0] item_out;
        logic [31:0] priority_out;
        logic [1:0]  status;
        logic        is_empty;
        logic [4:0]  entry_count;
    } spq_out_t;

    typedef struct packed {
        logic [31:0] item;
        logic [31:0] prio;
    } spq_entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } spq_cell_ctrl_t;

endpackage

FILE: rtl/sorted_priority_queue_core.sv
// sorted_priority_queue_core: bounded min-priority queue as a row of sorted shift cells
// an accepted request word gives its response word in the output register in the next cycle
// throughput: one request per cycle while responses are taken; every cell compares against the new priority in parallel
// the response register frees as it is taken, so requests flow while responses drain
// reset: entry count and response valid clear; slot contents are left as they are
// depends on spq_pkg and spq_cell
module sorted_priority_queue_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  spq_pkg::spq_in_t req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output spq_pkg::spq_out_t rsp
);

    localparam int DEPTH = spq_pkg::QUEUE_DEPTH;
    localparam int CW    = spq_pkg::COUNT_W;

    // occupancy and response register
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    spq_pkg::spq_out_t rsp_reg;
    spq_pkg::spq_out_t rsp_next;

    // chain wiring
    spq_pkg::spq_entry_t cell_entry [DEPTH];
    logic [DEPTH-1:0]    cell_stay;
    logic [DEPTH-1:0]    cell_occ;
    spq_pkg::spq_cell_ctrl_t ctrl;
    spq_pkg::spq_entry_t new_entry;

    logic accept;
    logic full;
    logic empty;
    logic [CW+4:0] count_ext;

    // response register frees when empty or being taken this cycle
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    assign new_entry.item = req.item_in;
    assign new_entry.prio = req.priority_in;

    // dropped inserts and empty removes leave the chain untouched
    assign ctrl.ins = accept && (req.cmd == spq_pkg::CMD_INSERT) && !full;
    assign ctrl.rem = accept && (req.cmd == spq_pkg::CMD_REMOVE) && !empty;

    // slot i holds a live entry when it sits below the count
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign cell_occ[gi] = (CW'(gi) < count_reg);

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .left_entry  ((gi == 0) ? new_entry : cell_entry[(gi == 0) ? 0 : gi - 1]),
                .right_entry ((gi == DEPTH - 1) ? cell_entry[gi]
                                                : cell_entry[(gi == DEPTH - 1) ? gi : gi + 1]),
                .occupied    (cell_occ[gi]),
                .left_stay   ((gi == 0) ? 1'b1 : cell_stay[(gi == 0) ? 0 : gi - 1]),
                .entry       (cell_entry[gi]),
                .stay        (cell_stay[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
            count_next = count_reg + CW'(1);
        else if (ctrl.rem)
            count_next = count_reg - CW'(1);
    end

    // entry_count is the low five bits of the new occupancy
    assign count_ext = {5'b0, count_next};

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (accept)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.item_out     = '0;
            rsp_next.priority_out = '0;
            rsp_next.status       = spq_pkg::ST_OK;
            if (req.cmd == spq_pkg::CMD_INSERT)
            begin
                if (full)
                    rsp_next.status = spq_pkg::ST_FULL;
            end
            else if (empty)
            begin
                rsp_next.status = spq_pkg::ST_EMPTY;
            end
            else
            begin
                // head of the chain is always the smallest priority
                rsp_next.item_out     = cell_entry[0].item;
                rsp_next.priority_out = cell_entry[0].prio;
            end
            rsp_next.is_empty    = (count_next == '0);
            rsp_next.entry_count = count_ext[4:0];
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // occupancy never runs past the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond queue depth");

    // head pair stays in order
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
        else $error("chain head out of priority order");

    // a stored insert grows the count by one
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow entry count");

    // remove on an empty queue reports empty and returns zero
    a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == spq_pkg::CMD_REMOVE) && empty)
        |=> (rsp_valid_reg && (rsp_reg.status == spq_pkg::ST_EMPTY)
             && (rsp_reg.item_out == '0)))
        else $error("empty remove not flagged");

endmodule

FILE: rtl/spq_cell.sv
// spq_cell: one slot of the sorted chain, holds an entry and shifts with its neighbors
// depends on spq_pkg
module spq_cell (
    input  logic                    clk,
    input  spq_pkg::spq_cell_ctrl_t ctrl,
    input  spq_pkg::spq_entry_t     new_entry,
    input  spq_pkg::spq_entry_t     left_entry,
    input  spq_pkg::spq_entry_t     right_entry,
    input  logic                    occupied,
    input  logic                    left_stay,
    output spq_pkg::spq_entry_t     entry,
    output logic                    stay
);

    spq_pkg::spq_entry_t entry_reg;
    spq_pkg::spq_entry_t entry_next;

    // entry keeps its slot on insert when it sorts at or before the new one
    assign stay  = occupied && (entry_reg.prio <= new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (!stay)
            begin
                // first slot that gives way takes the new word, the rest shift up
                if (left_stay)
                    entry_next = new_entry;
                else
                    entry_next = left_entry;
            end
        end
        else if (ctrl.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
